/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* rtl/tss_pkg.sv */
package tss_pkg;
  localparam int METRIC_SLOTS = 16;
  localparam int DEMAND_SLOTS = 32;
  localparam int TICK_BITS = 32;
  localparam int MS_W = $clog2(METRIC_SLOTS);
  localparam int DS_W = $clog2(DEMAND_SLOTS);
  localparam int MAX_RES = 16;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_REQUEST = 3'd2;
  localparam logic [2:0] OP_ADVANCE = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BACKWARDS = 2'd3;

  localparam logic [1:0] REG_HIGH = 2'd0;
  localparam logic [1:0] REG_NORMAL = 2'd1;
  localparam logic [1:0] REG_LOW = 2'd2;

  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [2:0] op;
    logic [15:0] metric_key;
    logic [1:0] tier;
    logic [31:0] demand_handle;
    logic [31:0] now_tick;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] new_demand;
    logic due_valid;
    logic [15:0] due_key;
    logic tracked;
    logic [1:0] eff_tier;
    logic periodic;
    logic [31:0] eff_interval;
    logic [31:0] due_tick;
    logic [5:0] demand_total;
    logic last;
  } res_t;

  function automatic logic [TICK_BITS-1:0] sat_add(input logic [TICK_BITS-1:0] a,
                                                   input logic [31:0] b);
    logic [TICK_BITS:0] s;
    logic [TICK_BITS:0] bx;
    bx = TICK_BITS >= 32 ? (TICK_BITS+1)'(b) : (TICK_BITS+1)'(b[TICK_BITS-1:0]);
    s = {1'b0, a} + bx;
    if (s[TICK_BITS] || (TICK_BITS < 32 && |(b >> TICK_BITS))) return TICK_MAX;
    return s[TICK_BITS-1:0];
  endfunction
endpackage

/* rtl/tiered_sampling_scheduler.sv */
// Channel | Bus          | Content
// in      | tdata 88 bit | op, metric_key, tier, demand_handle, now_tick
// out     | tdata 128    | result fields; tlast marks final result of a command
// cfg     | APB 32 bit   | high_interval 0x0, normal_interval 0x4, low_interval 0x8
// A command is captured in S_IDLE and executed in S_EXEC, where its result is registered.
// Advance loops S_PICK/S_OUT per due metric (at most 16), ends in S_ADV; result stalls hold it.
// Time is set by the single command engine; a 2-entry queue holds arrivals.
// rst_n synchronous: tables empty, intervals 1/4/16.
// A stalled result holds the engine; input queue keeps accepting until full.
module tiered_sampling_scheduler import tss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [87:0] in_tdata,   // op, metric_key, tier, demand_handle, now_tick, pad
  output logic out_tvalid,
  input  logic out_tready,
  output logic [127:0] out_tdata, // status, new_demand, due_valid, due_key, tracked,
                                  // eff_tier, periodic, eff_interval, due_tick,
                                  // demand_total, pad
  output logic out_tlast,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [31:0] high_r, normal_r, low_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  res_t r;
  logic [31:0] wv;

  assign cfg_pready = 1'b1;
  assign wv = (cfg_pwdata == 0) ? 32'd1 : cfg_pwdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= 32'd1;
      normal_r <= 32'd4;
      low_r <= 32'd16;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        REG_HIGH: high_r <= wv;
        REG_NORMAL: normal_r <= wv;
        REG_LOW: low_r <= wv;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_HIGH: cfg_prdata = high_r;
      REG_NORMAL: cfg_prdata = normal_r;
      REG_LOW: cfg_prdata = low_r;
      default: cfg_prdata = '0;
    endcase
  end

  assign in_cmd.op = in_tdata[2:0];
  assign in_cmd.metric_key = in_tdata[18:3];
  assign in_cmd.tier = in_tdata[20:19];
  assign in_cmd.demand_handle = in_tdata[52:21];
  assign in_cmd.now_tick = in_tdata[84:53];

  tss_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd(in_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  tss_engine u_eng (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .high_iv(high_r), .normal_iv(normal_r), .low_iv(low_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(r)
  );

  assign out_tdata = {3'd0, r.demand_total, r.due_tick, r.eff_interval, r.periodic,
                      r.eff_tier, r.tracked, r.due_key, r.due_valid, r.new_demand,
                      r.status};
  assign out_tlast = r.last;
endmodule

/* rtl/tss_cmd_fifo.sv */
module tss_cmd_fifo import tss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = cnt_r != 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (out_valid && out_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule

/* rtl/tss_engine.sv */
module tss_engine import tss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  input  logic [31:0] high_iv,
  input  logic [31:0] normal_iv,
  input  logic [31:0] low_iv,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_OUT = 3'd3;
  localparam logic [2:0] S_ADV = 3'd4;

  logic slot_valid_r [METRIC_SLOTS];
  logic [15:0] slot_key_r [METRIC_SLOTS];
  logic [31:0] slot_order_r [METRIC_SLOTS];
  logic [TICK_BITS-1:0] slot_due_r [METRIC_SLOTS];
  logic slot_pending_r [METRIC_SLOTS];
  logic [5:0] cnt_r [METRIC_SLOTS][4];
  logic dem_valid_r [DEMAND_SLOTS];
  logic [31:0] dem_id_r [DEMAND_SLOTS];
  logic [MS_W-1:0] dem_slot_r [DEMAND_SLOTS];
  logic [1:0] dem_tier_r [DEMAND_SLOTS];
  logic [31:0] next_handle_r, next_order_r;
  logic [TICK_BITS-1:0] cur_tick_r;

  logic [2:0] state_r;
  cmd_t c_r;
  logic [METRIC_SLOTS-1:0] due_r;
  logic [4:0] n_r;
  logic [MS_W-1:0] best_r;
  res_t res_r;
  logic res_v_r;

  assign cmd_ready = state_r == S_IDLE;
  assign res_valid = res_v_r;
  assign res = res_r;

  function automatic logic [1:0] etier(input logic [5:0] c3, input logic [5:0] c2,
                                       input logic [5:0] c1);
    if (c3 != 0) return 2'd3;
    if (c2 != 0) return 2'd2;
    if (c1 != 0) return 2'd1;
    return 2'd0;
  endfunction

  logic [1:0] et [METRIC_SLOTS];
  logic [31:0] iv [METRIC_SLOTS];
  logic [TICK_BITS-1:0] now_m;
  logic hit, free_s_ok, free_d_ok, dhit;
  logic [MS_W-1:0] hit_s, free_s, dslot;
  logic [DS_W-1:0] free_d, dh;
  logic [METRIC_SLOTS-1:0] due_c;
  logic any_due;
  logic [MS_W-1:0] best_c;
  // oldest-due selection tree, leaves at METRIC_SLOTS-1 and up
  logic tv [2*METRIC_SLOTS-1];
  logic [MS_W-1:0] ti [2*METRIC_SLOTS-1];
  logic [31:0] tord [2*METRIC_SLOTS-1];

  always_comb begin
    now_m = c_r.now_tick[TICK_BITS-1:0];
    hit = 1'b0; hit_s = '0; free_s_ok = 1'b0; free_s = '0;
    free_d_ok = 1'b0; free_d = '0; dhit = 1'b0; dh = '0;
    for (int i = 0; i < METRIC_SLOTS; i++) begin
      et[i] = etier(cnt_r[i][3], cnt_r[i][2], cnt_r[i][1]);
      case (et[i])
        2'd3: iv[i] = high_iv;
        2'd2: iv[i] = normal_iv;
        2'd1: iv[i] = low_iv;
        default: iv[i] = '0;
      endcase
      due_c[i] = slot_valid_r[i] && (slot_pending_r[i] ||
                 (iv[i] != 0 && slot_due_r[i] <= now_m));
    end
    for (int i = METRIC_SLOTS-1; i >= 0; i--) begin
      if (slot_valid_r[i] && slot_key_r[i] == c_r.metric_key) begin
        hit = 1'b1; hit_s = MS_W'(i);
      end
      if (!slot_valid_r[i]) begin
        free_s_ok = 1'b1; free_s = MS_W'(i);
      end
    end
    for (int i = DEMAND_SLOTS-1; i >= 0; i--) begin
      if (!dem_valid_r[i]) begin
        free_d_ok = 1'b1; free_d = DS_W'(i);
      end
      if (dem_valid_r[i] && dem_id_r[i] == c_r.demand_handle) begin
        dhit = 1'b1; dh = DS_W'(i);
      end
    end
    dslot = dem_slot_r[dh];
    for (int i = 0; i < METRIC_SLOTS; i++) begin
      tv[METRIC_SLOTS-1+i] = due_r[i];
      ti[METRIC_SLOTS-1+i] = MS_W'(i);
      tord[METRIC_SLOTS-1+i] = slot_order_r[i];
    end
    // equal orders keep the lower slot, which sits in the left subtree
    for (int n = METRIC_SLOTS-2; n >= 0; n--) begin
      if (tv[2*n+1] && (!tv[2*n+2] || tord[2*n+1] <= tord[2*n+2])) begin
        tv[n] = 1'b1; ti[n] = ti[2*n+1]; tord[n] = tord[2*n+1];
      end else begin
        tv[n] = tv[2*n+2]; ti[n] = ti[2*n+2]; tord[n] = tord[2*n+2];
      end
    end
    any_due = tv[0];
    best_c = ti[0];
  end

  res_t zr;
  always_comb begin
    zr = '0;
    zr.last = 1'b1;
  end

  logic [5:0] tot_h;
  logic [1:0] et_new;
  logic [31:0] iv_new;
  logic [TICK_BITS-1:0] cand;
  always_comb begin
    tot_h = cnt_r[hit_s][0] + cnt_r[hit_s][1] + cnt_r[hit_s][2] + cnt_r[hit_s][3];
    et_new = (c_r.tier > et[hit_s]) ? c_r.tier : et[hit_s];
    case (et_new)
      2'd3: iv_new = high_iv;
      2'd2: iv_new = normal_iv;
      2'd1: iv_new = low_iv;
      default: iv_new = '0;
    endcase
    cand = sat_add(cur_tick_r, iv_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_v_r <= 1'b0;
      next_handle_r <= '0;
      next_order_r <= '0;
      cur_tick_r <= '0;
      for (int i = 0; i < METRIC_SLOTS; i++) begin
        slot_valid_r[i] <= 1'b0;
        slot_pending_r[i] <= 1'b0;
        for (int t = 0; t < 4; t++) cnt_r[i][t] <= '0;
      end
      for (int i = 0; i < DEMAND_SLOTS; i++) dem_valid_r[i] <= 1'b0;
    end else begin
      if (res_v_r && res_ready) res_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            c_r <= cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!res_v_r || res_ready) begin
            res_r <= zr;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
            case (c_r.op)
              OP_ADD: begin
                if (!free_d_ok || (!hit && !free_s_ok)) begin
                  res_r.status <= ST_FULL;
                end else begin
                  res_r.new_demand <= next_handle_r;
                  next_handle_r <= next_handle_r + 32'd1;
                  dem_valid_r[free_d] <= 1'b1;
                  dem_id_r[free_d] <= next_handle_r;
                  dem_tier_r[free_d] <= c_r.tier;
                  if (hit) begin
                    dem_slot_r[free_d] <= hit_s;
                    cnt_r[hit_s][c_r.tier] <= cnt_r[hit_s][c_r.tier] + 6'd1;
                    if (iv_new != 0 && cand < slot_due_r[hit_s]) slot_due_r[hit_s] <= cand;
                  end else begin
                    dem_slot_r[free_d] <= free_s;
                    slot_valid_r[free_s] <= 1'b1;
                    slot_key_r[free_s] <= c_r.metric_key;
                    slot_order_r[free_s] <= next_order_r;
                    next_order_r <= next_order_r + 32'd1;
                    slot_due_r[free_s] <= cur_tick_r;
                    slot_pending_r[free_s] <= 1'b0;
                    for (int t = 0; t < 4; t++)
                      cnt_r[free_s][t] <= (2'(t) == c_r.tier) ? 6'd1 : 6'd0;
                  end
                end
              end
              OP_REMOVE: begin
                if (!dhit) begin
                  res_r.status <= ST_NOT_FOUND;
                end else begin
                  dem_valid_r[dh] <= 1'b0;
                  if (cnt_r[dslot][dem_tier_r[dh]] != 0)
                    cnt_r[dslot][dem_tier_r[dh]] <= cnt_r[dslot][dem_tier_r[dh]] - 6'd1;
                  if (cnt_r[dslot][0] + cnt_r[dslot][1] + cnt_r[dslot][2]
                      + cnt_r[dslot][3] <= 6'd1) begin
                    slot_valid_r[dslot] <= 1'b0;
                    slot_pending_r[dslot] <= 1'b0;
                  end
                end
              end
              OP_REQUEST: begin
                if (!hit) res_r.status <= ST_NOT_FOUND;
                else slot_pending_r[hit_s] <= 1'b1;
              end
              OP_QUERY: begin
                if (!hit) begin
                  res_r.status <= ST_NOT_FOUND;
                end else begin
                  res_r.tracked <= 1'b1;
                  res_r.eff_tier <= et[hit_s];
                  res_r.periodic <= iv[hit_s] != 0;
                  res_r.eff_interval <= iv[hit_s];
                  res_r.due_tick <= iv[hit_s] != 0 ? 32'(slot_due_r[hit_s]) : 32'd0;
                  res_r.demand_total <= tot_h;
                end
              end
              OP_ADVANCE: begin
                if (now_m < cur_tick_r) begin
                  res_r.status <= ST_BACKWARDS;
                end else begin
                  res_v_r <= 1'b0;
                  for (int i = 0; i < METRIC_SLOTS; i++) due_r[i] <= due_c[i];
                  n_r <= '0;
                  state_r <= S_PICK;
                end
              end
              default: ;
            endcase
          end
        end
        S_PICK: begin
          if (!any_due || n_r == 5'(MAX_RES)) begin
            state_r <= S_ADV;
          end else begin
            best_r <= best_c;
            due_r[best_c] <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_v_r || res_ready) begin
            res_r <= '0;
            res_r.due_valid <= 1'b1;
            res_r.due_key <= slot_key_r[best_r];
            res_r.last <= (n_r == 5'(MAX_RES-1)) || ((due_r & ~(METRIC_SLOTS'(1) << best_r)) == '0);
            res_v_r <= 1'b1;
            slot_pending_r[best_r] <= 1'b0;
            if (iv[best_r] != 0) slot_due_r[best_r] <= sat_add(now_m, iv[best_r]);
            n_r <= n_r + 5'd1;
            state_r <= S_PICK;
          end
        end
        S_ADV: begin
          if (n_r != 0) begin
            cur_tick_r <= now_m;
            state_r <= S_IDLE;
          end else if (!res_v_r || res_ready) begin
            cur_tick_r <= now_m;
            res_r <= zr;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/tss_checker.sv */
`include "assert_macros.svh"
module tss_checker (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic [127:0] out_tdata,
  input logic out_tlast,
  input logic cfg_pready
);
  `CHK_IMPL(a_pready, clk, rst_n, 1'b1, cfg_pready)
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CHK_IMPL(a_due_ok, clk, rst_n, out_tvalid && out_tdata[34], out_tdata[1:0] == 2'd0)
  `CHK_IMPL(a_nondue_last, clk, rst_n, out_tvalid && !out_tdata[34], out_tlast)
endmodule

bind tiered_sampling_scheduler tss_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast), .cfg_pready(cfg_pready)
);
